FILE: design/tbdl_pkg.sv
package tbdl_pkg;

    localparam int unsigned DATA_W      = 16;
    localparam int unsigned PRESENT_W   = 2;
    localparam int unsigned MAX_EVENTS  = 7;
    localparam int unsigned ACT_EVENTS  = 4;
    localparam int unsigned NAV_EVENTS  = 3;
    localparam int unsigned COUNT_W     = 3;

    localparam logic [DATA_W-1:0]    DEBOUNCE_RESET = 16'd30;
    localparam logic [DATA_W-1:0]    LONGPRESS_RESET = 16'd600;
    localparam logic [PRESENT_W-1:0] PRESENT_RESET  = 2'b11;

    // buttons_present bit positions
    localparam int unsigned BIT_ACTION = 0;
    localparam int unsigned BIT_NAV    = 1;

    typedef enum logic [1:0] {
        CFG_DEBOUNCE  = 2'd0,
        CFG_LONGPRESS = 2'd1,
        CFG_PRESENT   = 2'd2,
        CFG_SPARE     = 2'd3
    } cfg_index_t;

    typedef enum logic [2:0] {
        KEY_UP      = 3'd0,
        KEY_ESC     = 3'd1,
        KEY_USE     = 3'd2,
        KEY_CONFIRM = 3'd3,
        KEY_FIRE    = 3'd4
    } key_code_t;

    typedef struct packed {
        logic      pressed;
        key_code_t code;
    } event_t;

    typedef struct packed {
        logic [COUNT_W-1:0]         count;
        event_t [MAX_EVENTS-1:0]    slots;
    } burst_t;

    typedef struct packed {
        logic rise;
        logic fall;
        logic long_hit;
        logic long_fired;
    } btn_stat_t;

    function automatic event_t mk_event(key_code_t code, logic pressed);
        event_t e;
        e.code    = code;
        e.pressed = pressed;
        return e;
    endfunction

endpackage

FILE: design/tbdl_button.sv
module tbdl_button #(
    parameter int unsigned TIME_BITS = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          present,
    input  logic                          commit,
    input  logic [TIME_BITS-1:0]          now,
    input  logic                          pin,
    input  logic                          long_gate,
    input  logic [tbdl_pkg::DATA_W-1:0]   debounce_time,
    input  logic [tbdl_pkg::DATA_W-1:0]   long_press_time,
    output tbdl_pkg::btn_stat_t           stat
);

    logic                 raw_reg;
    logic                 stable_reg;
    logic [TIME_BITS-1:0] change_time_reg;
    logic [TIME_BITS-1:0] start_time_reg;
    logic                 long_fired_reg;

    logic                 stable_next;
    logic [TIME_BITS-1:0] change_time_next;
    logic [TIME_BITS-1:0] start_time_next;
    logic                 long_fired_next;
    logic                 long_fired_pre;
    logic [TIME_BITS-1:0] since_change;
    logic [TIME_BITS-1:0] since_press;
    logic [TIME_BITS-1:0] lp_limit;
    logic                 rise;
    logic                 fall;
    logic                 long_hit;

    // a zero long-press time acts as one
    assign lp_limit = (long_press_time == '0) ? TIME_BITS'(1)
                                              : TIME_BITS'(long_press_time);

    always_comb
    begin
        change_time_next = (pin != raw_reg) ? now : change_time_reg;
        since_change     = now - change_time_next;
        stable_next      = stable_reg;
        if ((stable_reg != pin) && (since_change >= TIME_BITS'(debounce_time)))
        begin
            stable_next = pin;
        end
        rise            = stable_next & ~stable_reg;
        fall            = ~stable_next & stable_reg;
        start_time_next = rise ? now : start_time_reg;
        long_fired_pre  = rise ? 1'b0 : long_fired_reg;
        since_press     = now - start_time_next;
        long_hit        = stable_next & long_gate & ~long_fired_pre
                          & (since_press >= lp_limit);
        long_fired_next = long_hit | long_fired_pre;
    end

    // absent button: no events
    assign stat.rise       = present & rise;
    assign stat.fall       = present & fall;
    assign stat.long_hit   = present & long_hit;
    assign stat.long_fired = long_fired_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_reg         <= 1'b0;
            stable_reg      <= 1'b0;
            change_time_reg <= '0;
            start_time_reg  <= '0;
            long_fired_reg  <= 1'b0;
        end
        else if (commit && present)
        begin
            raw_reg         <= pin;
            stable_reg      <= stable_next;
            change_time_reg <= change_time_next;
            start_time_reg  <= start_time_next;
            long_fired_reg  <= long_fired_next;
        end
    end

endmodule

FILE: design/tbdl_events.sv
module tbdl_events (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 commit,
    input  tbdl_pkg::btn_stat_t  nav_stat,
    input  tbdl_pkg::btn_stat_t  act_stat,
    output logic                 up_held,
    output tbdl_pkg::burst_t     burst
);

    logic                                    up_held_reg;
    logic                                    up_held_next;
    tbdl_pkg::event_t [tbdl_pkg::NAV_EVENTS-1:0] nav_ev;
    tbdl_pkg::event_t [tbdl_pkg::ACT_EVENTS-1:0] act_ev;
    logic [1:0]                              nav_len;
    logic [2:0]                              act_len;
    tbdl_pkg::event_t                        filler;

    assign up_held = up_held_reg;
    assign filler  = tbdl_pkg::mk_event(tbdl_pkg::KEY_UP, 1'b0);

    always_comb
    begin
        nav_ev  = {tbdl_pkg::NAV_EVENTS{filler}};
        nav_len = 2'd0;
        // rise, long hold and fall exclude each other within one sample
        priority if (nav_stat.rise)
        begin
            nav_ev[0] = tbdl_pkg::mk_event(tbdl_pkg::KEY_UP, 1'b1);
            nav_len   = 2'd1;
        end
        else if (nav_stat.long_hit)
        begin
            nav_ev[0] = tbdl_pkg::mk_event(tbdl_pkg::KEY_UP, 1'b0);
            nav_ev[1] = tbdl_pkg::mk_event(tbdl_pkg::KEY_ESC, 1'b1);
            nav_ev[2] = tbdl_pkg::mk_event(tbdl_pkg::KEY_ESC, 1'b0);
            nav_len   = 2'd3;
        end
        else if (nav_stat.fall && up_held_reg)
        begin
            nav_ev[0] = tbdl_pkg::mk_event(tbdl_pkg::KEY_UP, 1'b0);
            nav_len   = 2'd1;
        end
        else
        begin
            nav_len = 2'd0;
        end

        act_ev  = {tbdl_pkg::ACT_EVENTS{filler}};
        act_len = 3'd0;
        priority if (act_stat.long_hit)
        begin
            act_ev[0] = tbdl_pkg::mk_event(tbdl_pkg::KEY_USE, 1'b1);
            act_ev[1] = tbdl_pkg::mk_event(tbdl_pkg::KEY_USE, 1'b0);
            act_len   = 3'd2;
        end
        else if (act_stat.fall && !act_stat.long_fired)
        begin
            act_ev[0] = tbdl_pkg::mk_event(tbdl_pkg::KEY_CONFIRM, 1'b1);
            act_ev[1] = tbdl_pkg::mk_event(tbdl_pkg::KEY_CONFIRM, 1'b0);
            act_ev[2] = tbdl_pkg::mk_event(tbdl_pkg::KEY_FIRE, 1'b1);
            act_ev[3] = tbdl_pkg::mk_event(tbdl_pkg::KEY_FIRE, 1'b0);
            act_len   = 3'd4;
        end
        else
        begin
            act_len = 3'd0;
        end

        // append action events behind the navigation events
        burst.slots = {tbdl_pkg::MAX_EVENTS{filler}};
        for (int i = 0; i < tbdl_pkg::NAV_EVENTS; i++)
        begin
            burst.slots[i] = nav_ev[i];
        end
        unique case (nav_len)
            2'd0:
            begin
                for (int i = 0; i < tbdl_pkg::ACT_EVENTS; i++)
                begin
                    burst.slots[i] = act_ev[i];
                end
            end
            2'd1:
            begin
                for (int i = 0; i < tbdl_pkg::ACT_EVENTS; i++)
                begin
                    burst.slots[i + 1] = act_ev[i];
                end
            end
            2'd3:
            begin
                for (int i = 0; i < tbdl_pkg::ACT_EVENTS; i++)
                begin
                    burst.slots[i + 3] = act_ev[i];
                end
            end
            default:
            begin
                burst.slots = {tbdl_pkg::MAX_EVENTS{filler}};
            end
        endcase
        burst.count = {1'b0, nav_len} + act_len;

        up_held_next = up_held_reg;
        if (nav_stat.rise)
        begin
            up_held_next = 1'b1;
        end
        else if (nav_stat.long_hit || nav_stat.fall)
        begin
            up_held_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            up_held_reg <= 1'b0;
        end
        else if (commit)
        begin
            up_held_reg <= up_held_next;
        end
    end

endmodule

FILE: design/tbdl_drain.sv
module tbdl_drain (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    input  tbdl_pkg::burst_t              burst,
    output logic                          load_ok,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,
    output logic                          m_tlast
);

    tbdl_pkg::event_t [tbdl_pkg::MAX_EVENTS-1:0] slots_reg;
    tbdl_pkg::event_t [tbdl_pkg::MAX_EVENTS-1:0] slots_next;
    logic [tbdl_pkg::COUNT_W-1:0]               count_reg;
    logic [tbdl_pkg::COUNT_W-1:0]               count_next;
    logic                                       pop;

    assign m_tvalid = (count_reg != '0);
    assign m_tlast  = (count_reg == tbdl_pkg::COUNT_W'(1));
    assign m_tdata  = {4'b0000, slots_reg[0]};
    assign pop      = m_tvalid & m_tready;
    assign load_ok  = (count_reg == '0) || (m_tlast && m_tready);

    always_comb
    begin
        slots_next = slots_reg;
        count_next = count_reg;
        if (load)
        begin
            slots_next = burst.slots;
            count_next = burst.count;
        end
        else if (pop)
        begin
            // advance to the next queued event
            for (int i = 0; i < tbdl_pkg::MAX_EVENTS - 1; i++)
            begin
                slots_next[i] = slots_reg[i + 1];
            end
            count_next = count_reg - tbdl_pkg::COUNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        slots_reg <= slots_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule

FILE: design/two_button_debounce_longpress_unit.sv
// Channel   Dir  Fields (low bit up)                                     Width
// s_axis    in   tdata: now_time[31:0], action_pin, nav_pin, zero pad     40
// m_axis    out  tdata: key_code[2:0], key_pressed, zero pad; tlast=last   8
// cfg       in   cfg_addr 0 debounce, 1 long press, 2 buttons present     16
//
// A sample is held in the input register until the button logic commits
// it and loads its 0 to 7 key events into the event queue. Events leave
// one per cycle while m_tready is high, so the queue drain sets the rate
// of samples that carry events. A sample is taken every cycle while it
// yields no events or the queue is empty or emptying on its last event.
// Reset clears the button state to released and loads the default settings.
// An output stall holds the queue and, one sample later, s_tready.
module two_button_debounce_longpress_unit #(
    parameter int unsigned TIME_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // now_time[31:0], action_pin, nav_pin, pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // key_code[2:0], key_pressed, pad
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_wdata
);

    logic [tbdl_pkg::DATA_W-1:0]    debounce_reg;
    logic [tbdl_pkg::DATA_W-1:0]    longpress_reg;
    logic [tbdl_pkg::PRESENT_W-1:0] present_reg;

    logic                 in_valid_reg;
    logic [31:0]          now_reg;
    logic                 apin_reg;
    logic                 npin_reg;

    logic                 in_take;
    logic                 commit;
    logic                 load;
    logic                 load_ok;
    logic                 up_held;
    logic [TIME_BITS-1:0] now_w;
    tbdl_pkg::btn_stat_t  act_stat;
    tbdl_pkg::btn_stat_t  nav_stat;
    tbdl_pkg::burst_t     burst;

    assign now_w    = TIME_BITS'(now_reg);
    // a sample with no events commits even while the queue is busy
    assign commit   = in_valid_reg && (load_ok || (burst.count == '0));
    assign load     = commit && (burst.count != '0);
    assign s_tready = !in_valid_reg || commit;
    assign in_take  = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg  <= tbdl_pkg::DEBOUNCE_RESET;
            longpress_reg <= tbdl_pkg::LONGPRESS_RESET;
            present_reg   <= tbdl_pkg::PRESENT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (tbdl_pkg::cfg_index_t'(cfg_addr))
                tbdl_pkg::CFG_DEBOUNCE:  debounce_reg  <= cfg_wdata;
                tbdl_pkg::CFG_LONGPRESS: longpress_reg <= cfg_wdata;
                tbdl_pkg::CFG_PRESENT:   present_reg   <= cfg_wdata[tbdl_pkg::PRESENT_W-1:0];
                tbdl_pkg::CFG_SPARE:     ;
                default:                 ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (commit)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            now_reg  <= s_tdata[31:0];
            apin_reg <= s_tdata[32];
            npin_reg <= s_tdata[33];
        end
    end

    tbdl_button #(
        .TIME_BITS(TIME_BITS)
    ) u_act (
        .clk             (clk),
        .rst_n           (rst_n),
        .present         (present_reg[tbdl_pkg::BIT_ACTION]),
        .commit          (commit),
        .now             (now_w),
        .pin             (apin_reg),
        .long_gate       (1'b1),
        .debounce_time   (debounce_reg),
        .long_press_time (longpress_reg),
        .stat            (act_stat)
    );

    tbdl_button #(
        .TIME_BITS(TIME_BITS)
    ) u_nav (
        .clk             (clk),
        .rst_n           (rst_n),
        .present         (present_reg[tbdl_pkg::BIT_NAV]),
        .commit          (commit),
        .now             (now_w),
        .pin             (npin_reg),
        .long_gate       (up_held),
        .debounce_time   (debounce_reg),
        .long_press_time (longpress_reg),
        .stat            (nav_stat)
    );

    tbdl_events u_events (
        .clk      (clk),
        .rst_n    (rst_n),
        .commit   (commit),
        .nav_stat (nav_stat),
        .act_stat (act_stat),
        .up_held  (up_held),
        .burst    (burst)
    );

    tbdl_drain u_drain (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load),
        .burst    (burst),
        .load_ok  (load_ok),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

FILE: design/tbdl_checker.sv
module tbdl_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);

    logic m_xfer;

    assign m_xfer = m_tvalid && m_tready;

    // hold a stalled transaction
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled output transaction changed");

    // ENTER down is always followed at once by ENTER up
    a_enter_pair: assert property (@(posedge clk) disable iff (!rst_n)
        m_xfer && (m_tdata[3:0] == {1'b1, tbdl_pkg::KEY_CONFIRM}) |=>
            m_tvalid && (m_tdata[3:0] == {1'b0, tbdl_pkg::KEY_CONFIRM}) && !m_tlast)
        else $error("ENTER down not followed by ENTER up");

    // USE down is never the last event and USE up comes next
    a_use_pair: assert property (@(posedge clk) disable iff (!rst_n)
        m_xfer && (m_tdata[3:0] == {1'b1, tbdl_pkg::KEY_USE}) |-> !m_tlast ##1
            (m_tvalid && (m_tdata[3:0] == {1'b0, tbdl_pkg::KEY_USE})))
        else $error("USE down not followed by USE up");

    // ESCAPE down is followed by ESCAPE up
    a_esc_pair: assert property (@(posedge clk) disable iff (!rst_n)
        m_xfer && (m_tdata[3:0] == {1'b1, tbdl_pkg::KEY_ESC}) |-> !m_tlast ##1
            (m_tvalid && (m_tdata[3:0] == {1'b0, tbdl_pkg::KEY_ESC})))
        else $error("ESCAPE down not followed by ESCAPE up");

endmodule

bind two_button_debounce_longpress_unit tbdl_checker u_tbdl_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

FILE: verif/debounce_event_checker.sv
`timescale 1ns / 100ps

module debounce_event_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,   // now_time[31:0], action_pin, nav_pin, pad
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,   // key_code[2:0], key_pressed, pad
    input  logic        m_tlast,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_wdata,
    output int          mismatch_count,
    output int          events_pending,
    output int          events_checked
);

    localparam int ACT = 0;
    localparam int NAV = 1;

    typedef struct packed {
        tbdl_pkg::key_code_t code;
        logic                pressed;
        logic                last;
    } key_event_t;

    key_event_t expected_events[$];
    key_event_t sample_events[$];
    key_event_t want;

    logic [15:0] debounce_ms;
    logic [15:0] long_press_ms;
    logic [1:0]  present_mask;
    logic        raw_lvl     [2];
    logic        stable_lvl  [2];
    logic        long_done   [2];
    logic [31:0] raw_since   [2];
    logic [31:0] press_since [2];
    logic        up_down;

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("ERROR at %0t ns, key event %0d: %s", $realtime, events_checked, msg);
    endtask

    task automatic clear_state();
        debounce_ms   = tbdl_pkg::DEBOUNCE_RESET;
        long_press_ms = tbdl_pkg::LONGPRESS_RESET;
        present_mask  = tbdl_pkg::PRESENT_RESET;
        for (int b = 0; b < 2; b++)
        begin
            raw_lvl[b]     = 1'b0;
            stable_lvl[b]  = 1'b0;
            long_done[b]   = 1'b0;
            raw_since[b]   = '0;
            press_since[b] = '0;
        end
        up_down = 1'b0;
    endtask

    function automatic void add_event(tbdl_pkg::key_code_t code, logic pressed);
        key_event_t ev;
        ev.code    = code;
        ev.pressed = pressed;
        ev.last    = 1'b0;
        sample_events.push_back(ev);
    endfunction

    // A raw change restarts the timer; accept the level once it has held long enough.
    task automatic settle_pin(input int b, input logic [31:0] now, input logic pin);
        logic [31:0] held;
        if (pin != raw_lvl[b])
        begin
            raw_lvl[b]   = pin;
            raw_since[b] = now;
        end
        held = now - raw_since[b];
        if (stable_lvl[b] != raw_lvl[b] && held >= 32'(debounce_ms))
            stable_lvl[b] = raw_lvl[b];
    endtask

    task automatic predict_sample(input logic [31:0] now, input logic a_pin,
                                  input logic n_pin);
        logic [31:0] hold_ms;
        logic [31:0] held;
        logic        act_on;
        logic        nav_on;
        logic        a_prev;
        logic        n_prev;
        hold_ms = (long_press_ms == '0) ? 32'd1 : 32'(long_press_ms);
        act_on  = present_mask[tbdl_pkg::BIT_ACTION];
        nav_on  = present_mask[tbdl_pkg::BIT_NAV];
        a_prev  = stable_lvl[ACT];
        n_prev  = stable_lvl[NAV];
        sample_events.delete();

        if (act_on)
            settle_pin(ACT, now, a_pin);
        if (nav_on)
            settle_pin(NAV, now, n_pin);

        if (nav_on)
        begin
            if (stable_lvl[NAV] && !n_prev)
            begin
                press_since[NAV] = now;
                long_done[NAV]   = 1'b0;
                up_down          = 1'b1;
                add_event(tbdl_pkg::KEY_UP, 1'b1);
            end
            held = now - press_since[NAV];
            if (stable_lvl[NAV] && up_down && !long_done[NAV] && held >= hold_ms)
            begin
                add_event(tbdl_pkg::KEY_UP, 1'b0);
                up_down = 1'b0;
                add_event(tbdl_pkg::KEY_ESC, 1'b1);
                add_event(tbdl_pkg::KEY_ESC, 1'b0);
                long_done[NAV] = 1'b1;
            end
            if (!stable_lvl[NAV] && n_prev)
            begin
                if (up_down)
                    add_event(tbdl_pkg::KEY_UP, 1'b0);
                up_down = 1'b0;
            end
        end

        if (act_on)
        begin
            if (stable_lvl[ACT] && !a_prev)
            begin
                press_since[ACT] = now;
                long_done[ACT]   = 1'b0;
            end
            held = now - press_since[ACT];
            if (stable_lvl[ACT] && !long_done[ACT] && held >= hold_ms)
            begin
                add_event(tbdl_pkg::KEY_USE, 1'b1);
                add_event(tbdl_pkg::KEY_USE, 1'b0);
                long_done[ACT] = 1'b1;
            end
            // short release: enter then fire
            if (!stable_lvl[ACT] && a_prev && !long_done[ACT])
            begin
                add_event(tbdl_pkg::KEY_CONFIRM, 1'b1);
                add_event(tbdl_pkg::KEY_CONFIRM, 1'b0);
                add_event(tbdl_pkg::KEY_FIRE, 1'b1);
                add_event(tbdl_pkg::KEY_FIRE, 1'b0);
            end
        end

        if (sample_events.size() != 0)
            sample_events[sample_events.size() - 1].last = 1'b1;
        foreach (sample_events[i])
            expected_events.push_back(sample_events[i]);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_state();
            expected_events.delete();
            events_pending = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_events.size() == 0)
                    report_mismatch($sformatf("unexpected key code %0d pressed %0b last %0b",
                                              m_tdata[2:0], m_tdata[3], m_tlast));
                else
                begin
                    want = expected_events.pop_front();
                    if (m_tdata[2:0] != want.code)
                        report_mismatch($sformatf("key_code %0d, expected %0d",
                                                  m_tdata[2:0], want.code));
                    if (m_tdata[3] != want.pressed)
                        report_mismatch($sformatf("key_pressed %0b, expected %0b",
                                                  m_tdata[3], want.pressed));
                    if (m_tlast != want.last)
                        report_mismatch($sformatf("last_event %0b, expected %0b",
                                                  m_tlast, want.last));
                end
                events_checked++;
            end

            if (cfg_we)
            begin
                unique case (tbdl_pkg::cfg_index_t'(cfg_addr))
                    tbdl_pkg::CFG_DEBOUNCE:  debounce_ms   = cfg_wdata;
                    tbdl_pkg::CFG_LONGPRESS: long_press_ms = cfg_wdata;
                    tbdl_pkg::CFG_PRESENT:
                        present_mask = cfg_wdata[tbdl_pkg::PRESENT_W-1:0];
                    tbdl_pkg::CFG_SPARE:     ;
                    default:                 ;
                endcase
            end

            if (s_tvalid && s_tready)
                predict_sample(s_tdata[31:0], s_tdata[32], s_tdata[33]);

            events_pending = expected_events.size();
        end
    end

endmodule

FILE: verif/two_button_debounce_longpress_unit_test.sv
`timescale 1ns / 100ps

module two_button_debounce_longpress_unit_test;

    localparam int SETTLE_CYCLES   = 12;
    localparam int OUT_HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS     = 50;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // now_time[31:0], action_pin, nav_pin, pad
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // key_code[2:0], key_pressed, pad
    logic        m_tlast;
    logic        cfg_we;
    logic [1:0]  cfg_addr;
    logic [15:0] cfg_wdata;

    int          mismatch_count;
    int          events_pending;
    int          events_checked;

    logic [31:0] clock_ms;
    logic        act_target;
    logic        nav_target;
    logic [15:0] cur_debounce;
    logic [15:0] cur_long;
    bit          send_quiet;
    bit          recv_quiet;
    bit          hold_out;
    int          samples_sent;
    int          settings_applied;

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    two_button_debounce_longpress_unit #(
        .TIME_BITS(32)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    debounce_event_checker key_monitor (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .cfg_we         (cfg_we),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .mismatch_count (mismatch_count),
        .events_pending (events_pending),
        .events_checked (events_checked)
    );

    // Call at a falling edge; returns at the falling edge after the transaction.
    task automatic send_sample(input logic [31:0] t, input logic a, input logic n);
        int gap;
        gap = send_quiet ? 0 : $urandom_range(0, 13);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tdata  <= {6'd0, n, a, t};
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
        samples_sent++;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (events_pending != 0);
        // let a sample with no events clear the pipeline
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic apply_settings(input logic [15:0] db, input logic [15:0] lp,
                                  input logic [1:0] pm);
        cfg_we    <= 1'b1;
        cfg_addr  <= tbdl_pkg::CFG_DEBOUNCE;
        cfg_wdata <= db;
        @(negedge clk);
        cfg_addr  <= tbdl_pkg::CFG_LONGPRESS;
        cfg_wdata <= lp;
        @(negedge clk);
        cfg_addr  <= tbdl_pkg::CFG_PRESENT;
        cfg_wdata <= {14'd0, pm};
        @(negedge clk);
        cfg_we <= 1'b0;
        cur_debounce = db;
        cur_long     = lp;
        settings_applied++;
    endtask

    // Mostly press/hold/release gestures with bounce, time steps scaled to the settings.
    task automatic random_sample();
        int unsigned pick;
        int unsigned span_lp;
        int unsigned dt;
        logic        a;
        logic        n;
        span_lp = (cur_long == '0) ? 1 : cur_long;
        pick    = $urandom_range(0, 99);
        if (pick < 15)
            dt = $urandom_range(0, cur_debounce);
        else if (pick < 45)
            dt = cur_debounce + $urandom_range(0, 20);
        else if (pick < 75)
            dt = $urandom_range(0, span_lp);
        else if (pick < 95)
            dt = span_lp + $urandom_range(0, 200);
        else
            dt = $urandom;
        clock_ms = clock_ms + dt;
        if ($urandom_range(0, 4) == 0)
            act_target = ~act_target;
        if ($urandom_range(0, 4) == 0)
            nav_target = ~nav_target;
        a = act_target ^ ($urandom_range(0, 6) == 0);
        n = nav_target ^ ($urandom_range(0, 6) == 0);
        send_sample(clock_ms, a, n);
    endtask

    task automatic run_phase(input logic [15:0] db, input logic [15:0] lp,
                             input logic [1:0] pm, input int count,
                             input logic [31:0] start, input bit s_quiet,
                             input bit r_quiet, input bit pressure);
        wait_idle();
        apply_settings(db, lp, pm);
        clock_ms   = start;
        send_quiet = s_quiet;
        recv_quiet = r_quiet;
        hold_out   = pressure;
        repeat (count) random_sample();
        send_quiet = 1'b0;
        recv_quiet = 1'b0;
    endtask

    // Result side: random stalls per transaction, plus one long hold on request.
    initial
    begin
        int gap;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_out)
            begin
                m_tready <= 1'b0;
                repeat (OUT_HOLD_CYCLES) @(negedge clk);
                hold_out = 1'b0;
            end
            gap = recv_quiet ? 0 : $urandom_range(0, 13);
            if (gap != 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!(m_tvalid && m_tready));
        end
    end

    initial
    begin
        #2_000_000;
        $display("Timeout: key events still outstanding");
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        s_tvalid         = 1'b0;
        s_tdata          = '0;
        cfg_we           = 1'b0;
        cfg_addr         = tbdl_pkg::CFG_DEBOUNCE;
        cfg_wdata        = '0;
        act_target       = 1'b0;
        nav_target       = 1'b0;
        cur_debounce     = tbdl_pkg::DEBOUNCE_RESET;
        cur_long         = tbdl_pkg::LONGPRESS_RESET;
        send_quiet       = 1'b0;
        recv_quiet       = 1'b0;
        hold_out         = 1'b0;
        samples_sent     = 0;
        settings_applied = 0;
        rst_n            = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Navigation: press, long hold to escape, release after long press
        send_sample(32'd10,   1'b0, 1'b1);
        send_sample(32'd40,   1'b0, 1'b1);
        send_sample(32'd700,  1'b0, 1'b1);
        send_sample(32'd800,  1'b0, 1'b0);
        send_sample(32'd830,  1'b0, 1'b0);
        // Navigation short press
        send_sample(32'd900,  1'b0, 1'b1);
        send_sample(32'd930,  1'b0, 1'b1);
        send_sample(32'd950,  1'b0, 1'b0);
        send_sample(32'd980,  1'b0, 1'b0);
        // Action short press: enter and fire
        send_sample(32'd1000, 1'b1, 1'b0);
        send_sample(32'd1030, 1'b1, 1'b0);
        send_sample(32'd1040, 1'b0, 1'b0);
        send_sample(32'd1070, 1'b0, 1'b0);
        // Action long press, then a silent release
        send_sample(32'd1100, 1'b1, 1'b0);
        send_sample(32'd1130, 1'b1, 1'b0);
        send_sample(32'd1730, 1'b1, 1'b0);
        send_sample(32'd1740, 1'b0, 1'b0);
        send_sample(32'd1770, 1'b0, 1'b0);
        // Bounce shorter than the debounce time
        send_sample(32'd1800, 1'b1, 1'b0);
        send_sample(32'd1810, 1'b0, 1'b0);
        // Escape and enter/fire in one sample: seven events
        send_sample(32'd2000, 1'b1, 1'b1);
        send_sample(32'd2030, 1'b1, 1'b1);
        send_sample(32'd2040, 1'b0, 1'b1);
        send_sample(32'd2630, 1'b0, 1'b1);
        send_sample(32'd2700, 1'b0, 1'b0);
        send_sample(32'd2730, 1'b0, 1'b0);
        // Time stamps at the top of the range, all time bits high
        send_sample(32'hFFFF_FFFF, 1'b1, 1'b1);

        run_phase(16'd0,     16'd0,     2'b11, PHASE_ITEMS, $urandom, 1'b0, 1'b0, 1'b0);
        run_phase(16'd65535, 16'd65535, 2'b11, PHASE_ITEMS, $urandom, 1'b0, 1'b0, 1'b0);
        // Output held off while samples keep coming
        run_phase(16'd5,     16'd40,    2'b01, PHASE_ITEMS, $urandom, 1'b1, 1'b0, 1'b1);
        run_phase(16'd5,     16'd40,    2'b10, PHASE_ITEMS, $urandom, 1'b0, 1'b0, 1'b0);
        run_phase(16'd0,     16'd1,     2'b00, 12,          $urandom, 1'b0, 1'b0, 1'b0);
        // Start just below the wrap point, no idling on either side
        run_phase(16'd10,    16'd80,    2'b11, PHASE_ITEMS, 32'hFFFF_FF80, 1'b1, 1'b1, 1'b0);

        wait_idle();
        cfg_we    <= 1'b1;
        cfg_addr  <= tbdl_pkg::CFG_SPARE;
        cfg_wdata <= 16'hFFFF;
        @(negedge clk);
        run_phase(tbdl_pkg::DEBOUNCE_RESET, tbdl_pkg::LONGPRESS_RESET,
                  tbdl_pkg::PRESENT_RESET, PHASE_ITEMS,
                  $urandom, 1'b0, 1'b0, 1'b0);

        wait_idle();
        repeat (20) @(negedge clk);

        $display("Summary: %0d samples over %0d register settings, %0d key events checked",
                 samples_sent, settings_applied + 1, events_checked);
        $display("Covered zero and full-range timing, single and absent buttons, "
                 , "time wrap and output back-pressure");
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
